>>> src/skt_pkg.sv
// Shared types for the sorted key table: sequencer phases and cell control words.
// No dependencies; imported by every module of the block.
package skt_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_DEC
  } phase_t;

  // per-cell control, driven by the sequencer in the top level
  typedef struct packed {
    logic capture;    // register compare flags against the search key
    logic take_new;   // store the search key
    logic take_left;  // store the left neighbor's key (shift up)
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;  // stored key < search key
    logic eq;  // stored key == search key
  } cell_flag_t;

endpackage

>>> src/sorted_key_table_find_or_insert.sv
// Top level of the sorted key table: sequencer, fill count, row of key cells and
// result register. Depends on skt_pkg and skt_cell.
//
//  channel | direction | handshake            | word
//  in      | into      | in_valid / in_ready   | depth
//  out     | out of    | out_valid / out_ready | slot, created, full_res
//
// An item goes through accept, compare in every cell (flags registered),
// then decide and commit the shift/insert together with the result register.
// The next key is taken once the commit is done, even while the result waits.
// A result still waiting holds the decide step, which stretches the item.
// Reset clears the phase, the fill count and out_valid; cells above the count are never read.
module sorted_key_table_find_or_insert #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [skt_pkg::KEY_W-1:0]  depth,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [skt_pkg::SLOT_W-1:0]        slot,
  output logic                              created,
  output logic                              full_res
);
  import skt_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  function automatic logic [IW-1:0] encode(input logic [MAX_ENTRIES-1:0] oh);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (oh[i]) idx = idx | IW'(i);
    end
    return idx;
  endfunction

  phase_t                    phase, phase_next;
  logic signed [KEY_W-1:0]   key_reg;
  logic [CW-1:0]             count;

  logic signed [KEY_W-1:0]   cell_key  [MAX_ENTRIES];
  cell_flag_t                cell_flag [MAX_ENTRIES];
  cell_ctrl_t                cell_ctrl [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]    valid, lt_m, eq_m, bound;
  logic                      found, full, commit, insert;

  assign in_ready = (phase == PH_IDLE);
  assign found    = |eq_m;
  assign full     = (count == CW'(MAX_ENTRIES));
  assign commit   = (phase == PH_DEC) && (!out_valid || out_ready);
  assign insert   = !found && !full;

  generate
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);

      assign valid[i] = IDX < count;
      assign lt_m[i]  = valid[i] && cell_flag[i].lt;
      assign eq_m[i]  = valid[i] && cell_flag[i].eq;

      if (i == 0) begin : g_first
        assign bound[i] = !lt_m[i];
        assign cell_ctrl[i].take_left = 1'b0;
      end else begin : g_rest
        // sorted row: the lt flags form a run from slot 0, the insert point ends it
        assign bound[i] = lt_m[i-1] && !lt_m[i];
        assign cell_ctrl[i].take_left = commit && insert && valid[i-1] && !lt_m[i-1];
      end
      assign cell_ctrl[i].take_new = commit && insert && bound[i];
      assign cell_ctrl[i].capture  = (phase == PH_CMP);

      skt_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .search_key (key_reg),
        .left_key   ((i == 0) ? key_reg : cell_key[(i == 0) ? 0 : i-1]),
        .key        (cell_key[i]),
        .flag       (cell_flag[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (in_valid) phase_next = PH_CMP;
      PH_CMP:  phase_next = PH_DEC;
      PH_DEC:  if (commit) phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) key_reg <= depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit && insert) count <= count + CW'(1);
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      priority if (found) begin
        slot     <= SLOT_W'(encode(eq_m));
        created  <= 1'b0;
        full_res <= 1'b0;
      end else if (full) begin
        slot     <= '0;
        created  <= 1'b0;
        full_res <= 1'b1;
      end else begin
        slot     <= SLOT_W'(encode(bound));
        created  <= 1'b1;
        full_res <= 1'b0;
      end
    end
  end

endmodule

>>> src/skt_cell.sv
// One slot of the sorted key table: a stored key, its compare flags, and the
// load path from the left neighbor. Depends on skt_pkg.
module skt_cell (
  input  logic                              clk,
  input  skt_pkg::cell_ctrl_t               ctrl,
  input  logic signed [skt_pkg::KEY_W-1:0]  search_key,
  input  logic signed [skt_pkg::KEY_W-1:0]  left_key,
  output logic signed [skt_pkg::KEY_W-1:0]  key,
  output skt_pkg::cell_flag_t               flag
);
  import skt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.take_new) begin
      key <= search_key;
    end else if (ctrl.take_left) begin
      key <= left_key;
    end
    if (ctrl.capture) begin
      flag.lt <= key < search_key;
      flag.eq <= key == search_key;
    end
  end

endmodule

>>> src/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and the top level's ports.
module skt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [skt_pkg::KEY_W-1:0]  depth,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [skt_pkg::SLOT_W-1:0]        slot,
  input logic                              created,
  input logic                              full_res
);
  import skt_pkg::*;

  // one key in flight: no accept in the cycle right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a key is in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(created && full_res))
    else $error("created and full_res both set");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_res) |-> (slot == '0))
    else $error("full result with nonzero slot");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(slot) && $stable(created) && $stable(full_res)))
    else $error("stalled result changed");

  logic unused_in;
  assign unused_in = ^depth;

endmodule

bind sorted_key_table_find_or_insert skt_checker u_skt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .depth     (depth),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .slot      (slot),
  .created   (created),
  .full_res  (full_res)
);

>>> sim/testbench.sv
// Testbench for sorted_key_table_find_or_insert: drives depth words, predicts slot, created
// and full_res from a shadow copy of the sorted table, and checks every result in order.
// Depends on skt_pkg and the block's RTL; nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int TABLE_N     = 16;
  localparam int N_RANDOM    = 1230;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 10;

  localparam logic signed [KEY_W-1:0] DIRECTED [18] = '{
    32'sd0, 32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
    32'sh80000000, 32'sd1, 32'sd3, 32'sd2, -32'sd2, 32'sh55555555,
    32'shaaaaaaaa, 32'sh7ffffffe, 32'sh80000001, -32'sd1, 32'sd2, 32'sh55555555
  };

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              created;
    logic              full_res;
  } slot_result_t;

  class slot_scoreboard;
    logic signed [KEY_W-1:0] shadow_keys [TABLE_N];
    int                      shadow_n;
    slot_result_t            expected_slots [$];
    int n_keys, n_inserts, n_hits, n_full, n_checked, n_errors;

    function new();
      shadow_n  = 0;
      n_keys    = 0;
      n_inserts = 0;
      n_hits    = 0;
      n_full    = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    // find the key, else flag a full table, else insert it at the count of smaller keys
    function void note_depth(logic signed [KEY_W-1:0] key);
      slot_result_t r;
      int below;
      int hit;
      bit found;
      below = 0;
      hit   = 0;
      found = 0;
      r     = '0;
      n_keys++;
      for (int i = 0; i < shadow_n; i++) begin
        if (shadow_keys[i] < key) below++;
        else if (shadow_keys[i] == key) begin
          found = 1;
          hit   = i;
        end
      end
      if (found) begin
        r.slot = hit[SLOT_W-1:0];
        n_hits++;
      end else if (shadow_n >= TABLE_N) begin
        r.full_res = 1'b1;
        n_full++;
      end else begin
        for (int i = shadow_n; i > below; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[below] = key;
        shadow_n++;
        r.slot    = below[SLOT_W-1:0];
        r.created = 1'b1;
        n_inserts++;
      end
      expected_slots.push_back(r);
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      n_checked++;
      if (expected_slots.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("ERROR: result slot=%0d created=%0b full=%0b with no word pending",
                   got.slot, got.created, got.full_res);
      end else begin
        want = expected_slots.pop_front();
        if (got.slot !== want.slot || got.created !== want.created ||
            got.full_res !== want.full_res) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("ERROR: result %0d: slot %0d/%0d created %0b/%0b full %0b/%0b (exp/got)",
                     n_checked, want.slot, got.slot, want.created, got.created,
                     want.full_res, got.full_res);
        end
      end
    endfunction

    function void check_drained();
      if (expected_slots.size() != 0) begin
        n_errors += expected_slots.size();
        $display("ERROR: %0d results never arrived", expected_slots.size());
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [KEY_W-1:0] depth;
  logic                    out_valid;
  logic                    out_ready;
  logic [SLOT_W-1:0]       slot;
  logic                    created;
  logic                    full_res;

  slot_scoreboard sb = new();
  int idle_cycles = 0;

  sorted_key_table_find_or_insert #(
    .MAX_ENTRIES(TABLE_N)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .depth    (depth),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .slot     (slot),
    .created  (created),
    .full_res (full_res)
  );

  always #1 clk = ~clk;

  // handshakes and watchdog, sampled on the values present at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_depth(depth);
      if (out_valid && out_ready) sb.check_result({slot, created, full_res});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  // receiver: stretches of different stall patterns, one long hold-off
  initial begin
    int mode;
    int span;
    int k;
    bit held_off;
    held_off = 0;
    k = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && sb.n_keys >= 500) begin
        held_off = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 3 == 0);
        endcase
        k++;
        @(posedge clk);
      end
    end
  end

  task automatic send_depth(input logic signed [KEY_W-1:0] key);
    in_valid <= 1'b1;
    depth    <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      depth    <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_slots.size() != 0);
  endtask

  // mostly keys already stored or their neighbors, so compares hit the lt/eq boundary
  function automatic logic signed [KEY_W-1:0] pick_depth();
    logic signed [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 9);
    k = $urandom;
    if (sb.shadow_n > 0 && r <= 5) begin
      k = sb.shadow_keys[$urandom_range(0, sb.shadow_n - 1)];
      if (r >= 4) k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end else if (r == 6) begin
      case ($urandom_range(0, 3))
        0: k = 32'sh80000000;
        1: k = 32'sh7fffffff;
        2: k = 32'sd0;
        default: k = -32'sd1;
      endcase
    end
    return k;
  endfunction

  initial begin
    int sent;
    int burst;
    in_valid  <= 1'b0;
    depth     <= '0;
    rst       <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_depth(DIRECTED[i]);
      idle_gap($urandom_range(0, 2));
    end
    wait_drained();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_depth(pick_depth());
        sent++;
        if (sent == 600) wait_drained();
      end
      idle_gap($urandom_range(0, 6));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    sb.check_drained();
    $display("run: %0d keys, %0d inserted, %0d found, %0d refused on a full table",
             sb.n_keys, sb.n_inserts, sb.n_hits, sb.n_full);
    $display("run: %0d results checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
